// ===== sv/assert_macros.svh =====
// Assertion macros used by the scheduler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent property checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen on a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== sv/pps_pkg.sv =====
// Types, constants and controller encodings for the priority scheduler.
`default_nettype none

package pps_pkg;

  localparam int unsigned MAX_SLOTS = 16;
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned PRIO_BITS = 8;
  localparam int unsigned IDX_W     = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned SLOT_W    = 4;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [PRIO_BITS-1:0] prio_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [MAX_SLOTS-1:0] mask_t;

  // Request action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    time_t             arrival;
    time_t             burst;
    prio_t             prio;
  } req_t;

  typedef struct packed {
    logic              ran;
    logic [SLOT_W-1:0] run_slot;
    time_t             tick_end;
    logic              finished;
    time_t             completion;
    time_t             turnaround;
    time_t             waiting;
    logic              all_done;
  } rsp_t;

  // One row of the process table memory.
  typedef struct packed {
    time_t arrival;
    time_t burst;
    time_t remain;
    prio_t prio;
  } row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_CALC,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load_wr;
    logic scan_clr;
    logic scan_rd;
    logic clk_adv;
    logic calc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/preemptive_priority_scheduler_core.sv =====
// Top level of the preemptive priority scheduler core.
`default_nettype none

// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  in_req_i  (pps_pkg::req_t)
// result    out        out_valid_o / out_stall_i out_rsp_o (pps_pkg::rsp_t)
// config    in         cfg_we_i                 cfg_wdata_i (process count)
//
// A load request is taken while idle and produces no result.
// A tick request sweeps the single read port of the process table one slot
// per cycle over the N slots in use to find the lowest priority number.
// Reset clears the clock, the busy flags of all slots and the process count
// returns to one; table contents stay undefined until loaded.
// A stalled result holds in the output register while the next request is
// taken; a tick only waits in its emit state while that register is full and stalled.

module preemptive_priority_scheduler_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pps_pkg::req_t              in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pps_pkg::rsp_t              out_rsp_o,
  input  logic                       cfg_we_i,
  input  logic [pps_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import pps_pkg::*;

  logic [CFG_W-1:0] pcount_q;
  cnt_t             n_c;
  mask_t            use_mask;
  cmd_t             cmd;
  sts_t             sts;

  // Process count register; zero and oversized values are clamped on use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      pcount_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (pcount_q == '0) begin
      n_c = CNT_W'(1);
    end else if (32'(pcount_q) > MAX_SLOTS) begin
      n_c = CNT_W'(MAX_SLOTS);
    end else begin
      n_c = CNT_W'(pcount_q);
    end
  end

  // Slots below the count take part in the all-done check.
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      use_mask[i] = (CNT_W'(i) < n_c);
    end
  end

  pps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_req_i.action),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .n_i         (n_c),
    .use_mask_i  (use_mask),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== sv/pps_ctrl.sv =====
// Controller state machine that sequences loads and scheduling ticks.
`default_nettype none

module pps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_action_i,
  output logic          in_stall_o,
  input  pps_pkg::sts_t sts_i,
  output pps_pkg::cmd_t cmd_o
);
  import pps_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_action_i == ACT_TICK)) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_PICK;
      S_PICK:  state_d = S_CALC;
      S_CALC:  state_d = S_EMIT;
      S_EMIT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_wr  = in_valid_i && (in_action_i == ACT_LOAD);
        cmd_o.scan_clr = in_valid_i && (in_action_i == ACT_TICK);
      end
      S_SCAN:  cmd_o.scan_rd = 1'b1;
      S_DRAIN: cmd_o = '0;
      S_PICK:  cmd_o.clk_adv = 1'b1;
      S_CALC:  cmd_o.calc = 1'b1;
      S_EMIT:  cmd_o.emit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/pps_dp.sv =====
// Datapath: process table memory, priority scan, clock and result register.
`default_nettype none
`include "assert_macros.svh"

module pps_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pps_pkg::req_t  in_req_i,
  input  pps_pkg::cnt_t  n_i,
  input  pps_pkg::mask_t use_mask_i,
  input  pps_pkg::cmd_t  cmd_i,
  output pps_pkg::sts_t  sts_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pps_pkg::rsp_t  out_rsp_o
);
  import pps_pkg::*;

  row_t  mem_q [MAX_SLOTS];
  row_t  rd_q;
  idx_t  rd_addr;
  idx_t  wr_addr;
  row_t  wr_row;
  logic  wr_en;

  idx_t  idx_q, cmp_idx_q, pick_q;
  logic  cmp_vld_q, found_q, fin_q;
  prio_t best_q;
  mask_t busy_q;
  time_t clk_q, turn_q, burst_q;
  logic  out_valid_q;
  rsp_t  out_q;

  logic  eligible, take;
  time_t wait_c;

  // Single write port, single registered read port.
  assign rd_addr = cmd_i.scan_rd ? idx_q : pick_q;
  assign wr_en   = cmd_i.load_wr || (cmd_i.calc && found_q);
  assign wr_addr = cmd_i.load_wr ? IDX_W'(in_req_i.slot) : pick_q;

  always_comb begin
    if (cmd_i.load_wr) begin
      wr_row.arrival = in_req_i.arrival;
      wr_row.burst   = in_req_i.burst;
      wr_row.remain  = in_req_i.burst;
      wr_row.prio    = in_req_i.prio;
    end else begin
      wr_row        = rd_q;
      wr_row.remain = rd_q.remain - TIME_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_row;
    rd_q <= mem_q[rd_addr];
  end

  // Compare stage sees the row read in the previous cycle.
  assign eligible = cmp_vld_q && busy_q[cmp_idx_q] && (rd_q.arrival <= clk_q);
  assign take     = eligible && (!found_q || (rd_q.prio < best_q));

  assign sts_o.scan_last = (CNT_W'(idx_q) == (n_i - CNT_W'(1)));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      pick_q    <= '0;
      best_q    <= '0;
      busy_q    <= '0;
      clk_q     <= '0;
      fin_q     <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.scan_rd) begin
        cmp_idx_q <= idx_q;
        idx_q     <= idx_q + IDX_W'(1);
      end
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        pick_q  <= '0;
      end else if (take) begin
        found_q <= 1'b1;
        best_q  <= rd_q.prio;
        pick_q  <= cmp_idx_q;
      end
      if (cmd_i.load_wr) begin
        busy_q[IDX_W'(in_req_i.slot)] <= (in_req_i.burst != '0);
      end
      if (cmd_i.clk_adv && (clk_q != '1)) begin
        clk_q <= clk_q + TIME_BITS'(1);
      end
      if (cmd_i.calc) begin
        fin_q <= found_q && (rd_q.remain == TIME_BITS'(1));
        if (found_q && (rd_q.remain == TIME_BITS'(1))) busy_q[pick_q] <= 1'b0;
      end
    end
  end

  // Turnaround is registered in the calc step; the waiting time is derived from it combinationally.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      turn_q  <= (clk_q >= rd_q.arrival) ? (clk_q - rd_q.arrival) : '0;
      burst_q <= rd_q.burst;
    end
  end

  assign wait_c = (turn_q >= burst_q) ? (turn_q - burst_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.ran        <= found_q;
      out_q.run_slot   <= found_q ? SLOT_W'(pick_q) : '0;
      out_q.tick_end   <= clk_q;
      out_q.finished   <= fin_q;
      out_q.completion <= fin_q ? clk_q : '0;
      out_q.turnaround <= fin_q ? turn_q : '0;
      out_q.waiting    <= fin_q ? wait_c : '0;
      out_q.all_done   <= ((busy_q & use_mask_i) == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `ASSERT_PROP(a_pick_busy, clk_i, rst_ni,
               cmd_i.clk_adv && found_q |-> busy_q[pick_q], "picked slot has no work")
  `ASSERT_PROP(a_fin_clears, clk_i, rst_ni,
               cmd_i.calc && found_q && rd_q.remain == TIME_BITS'(1)
               |=> !busy_q[$past(pick_q)], "finished slot still busy")
  `ASSERT_NEVER(a_fin_ran, clk_i, rst_ni,
                out_valid_q && out_q.finished && !out_q.ran, "finish reported on an idle tick")
  `ASSERT_PROP(a_clk_mono, clk_i, rst_ni, clk_q >= $past(clk_q), "clock moved backward")

endmodule

`default_nettype wire
